FILE: sv/mccl_pkg.sv
// shared types, field widths and request/status codes of the cc learn mapper
package mccl_pkg;

    // field widths
    localparam int REQ_W  = 3;
    localparam int CHAN_W = 4;
    localparam int CC_W   = 7;
    localparam int VAL_W  = 7;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;
    localparam int POS_W  = 11;
    localparam int KEY_W  = CHAN_W + CC_W;

    // table rows per channel, full-scale controller value, fader step per scale unit
    localparam int CC_SPAN    = 128;
    localparam int VAL_MAX    = 127;
    localparam int FADER_UNIT = 137;
    localparam int POS_SAT    = 2047;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CC     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ARM    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DISARM = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_ACK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FADER   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LEARNED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISS    = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] strip;
        logic [IDX_W-1:0] dest;
        logic             from_input;
    } t_target;

    typedef struct packed {
        logic    valid;
        t_target tgt;
    } t_entry;

endpackage

FILE: sv/mccl_ram.sv
// generic simple dual-port ram with registered read
module mccl_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/mccl_scale.sv
// fader scaler: registered value*137*scale, /127, saturated to 11 bits
module mccl_scale #(
    parameter int SCALE_FACTOR = 8
) (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [mccl_pkg::VAL_W-1:0] i_value,
    output logic [mccl_pkg::POS_W-1:0] o_pos
);

    localparam int unsigned RAW = mccl_pkg::FADER_UNIT * SCALE_FACTOR;
    localparam int PW = $clog2(mccl_pkg::VAL_MAX * RAW + 1);
    // reciprocal of 127, exact for every product below 2**PW
    localparam int K = PW + 7;
    localparam int unsigned M = ((1 << K) + mccl_pkg::VAL_MAX - 1) / mccl_pkg::VAL_MAX;
    localparam int MW = $clog2(M + 1);
    localparam int FW = PW + MW;

    logic [PW-1:0] r_prod;
    logic [PW-1:0] n_prod;
    logic [FW-1:0] full;
    logic [31:0]   quot;

    assign n_prod = PW'(i_value) * PW'(RAW);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign full  = FW'(r_prod) * FW'(M);
    assign quot  = 32'(full >> K);
    assign o_pos = (quot > 32'(mccl_pkg::POS_SAT)) ? mccl_pkg::POS_W'(mccl_pkg::POS_SAT)
                                                   : quot[mccl_pkg::POS_W-1:0];

endmodule

FILE: sv/midi_cc_learn_mapper.sv
// cc learn mapper: one result word per request, written to the output register from execute
// one request at a time: table read at accept, then result; s_axis_tready is low in between
// clear-all acknowledges, then holds s_axis_tready low while all NUM_CHANNELS*128 table rows
// are swept; reset runs the same sweep before the first request
// reset clears the learn state and the output valid; table contents come from the sweep
module midi_cc_learn_mapper #(
    parameter int NUM_CHANNELS = 16,
    parameter int MAX_STRIPS   = 64,
    parameter int NUM_DESTS    = 64,
    parameter int SCALE_FACTOR = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // channel[3:0], controller[10:4], cc_value[17:11], target_strip[23:18],
    // target_dest[29:24], target_input[30], zero[31]
    input  logic [31:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // strip[5:0], dest[11:6], from_input[12], position[23:13]
    output logic [23:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser
);

    localparam int DEPTH = NUM_CHANNELS * mccl_pkg::CC_SPAN;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $bits(mccl_pkg::t_entry);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} t_state;
    typedef enum logic [2:0] {OP_ACK, OP_LEARNED, OP_MISS, OP_LOOKUP, OP_WIPE} t_op;

    // input word fields
    logic [mccl_pkg::REQ_W-1:0]  req;
    logic [mccl_pkg::CHAN_W-1:0] chan;
    logic [mccl_pkg::CC_W-1:0]   cc;
    logic [mccl_pkg::VAL_W-1:0]  val;
    mccl_pkg::t_target           in_tgt;
    logic [mccl_pkg::KEY_W-1:0]  key;
    logic [AW-1:0]               addr;
    logic                        chan_ok;
    logic                        tgt_ok;
    logic                        acc;
    logic                        out_free;

    t_state                       r_state, n_state;
    t_op                          r_op, n_op;
    logic [AW-1:0]                r_clr_addr, n_clr_addr;
    logic                         r_learn_armed, n_learn_armed;
    mccl_pkg::t_target            r_learn_tgt, n_learn_tgt;
    mccl_pkg::t_target            r_res_tgt, n_res_tgt;
    logic                         r_out_valid, n_out_valid;
    logic [mccl_pkg::STAT_W-1:0]  r_out_status, n_out_status;
    mccl_pkg::t_target            r_out_tgt, n_out_tgt;
    logic [mccl_pkg::POS_W-1:0]   r_out_pos, n_out_pos;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    mccl_pkg::t_entry             ram_wdata;
    mccl_pkg::t_entry             ram_rdata;
    logic [EW-1:0]                ram_rdata_raw;
    logic [mccl_pkg::POS_W-1:0]   scaled_pos;

    assign req               = s_axis_tuser;
    assign chan              = s_axis_tdata[3:0];
    assign cc                = s_axis_tdata[10:4];
    assign val               = s_axis_tdata[17:11];
    assign in_tgt.strip      = s_axis_tdata[23:18];
    assign in_tgt.dest       = s_axis_tdata[29:24];
    assign in_tgt.from_input = s_axis_tdata[30];

    assign key     = {chan, cc};
    assign addr    = key[AW-1:0];
    assign chan_ok = {1'b0, chan} < 5'(NUM_CHANNELS);
    assign tgt_ok  = ({1'b0, in_tgt.strip} < 7'(MAX_STRIPS)) &&
                     ({1'b0, in_tgt.dest} < 7'(NUM_DESTS));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    mccl_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (acc),
        .i_raddr (addr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = ram_rdata_raw;

    mccl_scale #(
        .SCALE_FACTOR (SCALE_FACTOR)
    ) u_scale (
        .i_clk   (i_clk),
        .i_load  (acc),
        .i_value (val),
        .o_pos   (scaled_pos)
    );

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_clr_addr    = r_clr_addr;
        n_learn_armed = r_learn_armed;
        n_learn_tgt   = r_learn_tgt;
        n_res_tgt     = r_res_tgt;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_status  = r_out_status;
        n_out_tgt     = r_out_tgt;
        n_out_pos     = r_out_pos;
        ram_we        = 1'b0;
        ram_waddr     = addr;
        ram_wdata     = '0;

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    n_state = ST_EXEC;
                    n_op    = OP_ACK;
                    case (req)
                        mccl_pkg::REQ_CC: begin
                            if (!chan_ok) begin
                                n_op = OP_MISS;
                            end else if (r_learn_armed) begin
                                // learn completes here; the target is written straight in
                                ram_we          = 1'b1;
                                ram_wdata.valid = 1'b1;
                                ram_wdata.tgt   = r_learn_tgt;
                                n_res_tgt       = r_learn_tgt;
                                n_learn_armed   = 1'b0;
                                n_learn_tgt     = '0;
                                n_op            = OP_LEARNED;
                            end else begin
                                n_op = OP_LOOKUP;
                            end
                        end
                        mccl_pkg::REQ_ARM: begin
                            if (tgt_ok) begin
                                n_learn_armed = 1'b1;
                                n_learn_tgt   = in_tgt;
                            end
                        end
                        mccl_pkg::REQ_DISARM: begin
                            n_learn_armed = 1'b0;
                        end
                        mccl_pkg::REQ_REMOVE: begin
                            ram_we = chan_ok;
                        end
                        mccl_pkg::REQ_CLEAR: begin
                            n_op = OP_WIPE;
                        end
                        default: begin
                            n_op = OP_ACK;
                        end
                    endcase
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = mccl_pkg::STAT_ACK;
                    n_out_tgt    = '0;
                    n_out_pos    = '0;
                    n_state      = ST_IDLE;
                    case (r_op)
                        OP_LEARNED: begin
                            n_out_status = mccl_pkg::STAT_LEARNED;
                            n_out_tgt    = r_res_tgt;
                        end
                        OP_MISS: begin
                            n_out_status = mccl_pkg::STAT_MISS;
                        end
                        OP_LOOKUP: begin
                            if (ram_rdata.valid) begin
                                n_out_status = mccl_pkg::STAT_FADER;
                                n_out_tgt    = ram_rdata.tgt;
                                n_out_pos    = scaled_pos;
                            end else begin
                                n_out_status = mccl_pkg::STAT_MISS;
                            end
                        end
                        OP_WIPE: begin
                            n_state    = ST_CLEAR;
                            n_clr_addr = '0;
                        end
                        default: begin
                            n_out_status = mccl_pkg::STAT_ACK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_op          <= OP_ACK;
            r_clr_addr    <= '0;
            r_learn_armed <= 1'b0;
            r_learn_tgt   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_op          <= n_op;
            r_clr_addr    <= n_clr_addr;
            r_learn_armed <= n_learn_armed;
            r_learn_tgt   <= n_learn_tgt;
            r_res_tgt     <= n_res_tgt;
            r_out_valid   <= n_out_valid;
            r_out_status  <= n_out_status;
            r_out_tgt     <= n_out_tgt;
            r_out_pos     <= n_out_pos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_out_pos, r_out_tgt.from_input, r_out_tgt.dest, r_out_tgt.strip};

`ifndef SYNTH
    // a fresh result word only ever comes out of the execute step
    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_EXEC))
        else $error("result word appeared without an execute step");

    // a cc event on a valid channel with learn armed always disarms it
    a_learn_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && req == mccl_pkg::REQ_CC && chan_ok && r_learn_armed) |=> !r_learn_armed)
        else $error("learn still armed after a learning cc event");

    // only a fader update carries a position
    a_pos_only_on_fader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != mccl_pkg::STAT_FADER) |-> (r_out_pos == '0))
        else $error("non-zero fader position on a non-update word");
`endif

endmodule
